// ===== hw/rtl/rhr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhr_pkg: shared types and constants for the RGB hue rotator
// Channel width, hue arithmetic widths, sextant codes and the pipeline word.
// ----------------------------------------------------------------------------
package rhr_pkg;

    // Pixel channel width and packed pixel width
    localparam int CHAN_W  = 8;
    localparam int PIX_W   = 3 * CHAN_W;

    // Shift register width (fixed by the register) and hue constants
    localparam int SHIFT_W  = 16;
    localparam int DEG_FULL = 360;
    localparam int DEG_SEXT = 60;

    // Hue in 0..360 and the sum before the wrap, up to 719
    localparam int HUE_W  = 9;
    localparam int HSUM_W = HUE_W + 1;

    // Offset inside a sextant, 0..59
    localparam int J_W = 6;

    // 60 * channel difference and (difference * j) both fit here
    localparam int PROD_W = CHAN_W + 6;

    // Quotient of the hue divide is at most 60
    localparam int HUE_Q_W   = 6;
    localparam int HUE_S2_LO = 3;

    // Quotient of shift / 360 is at most 182
    localparam int MOD_Q_W   = 8;
    localparam int MOD_S1_LO = 5;
    localparam int MOD_S2_LO = 2;

    // Quotient of (difference * j) / 60 is below 2^CHAN_W
    localparam int PQ_S7_LO = CHAN_W / 2;

    // Payload stages ahead of the output register
    localparam int NSTG = 8;

    // Sextants, named by the hue at which each starts
    typedef enum logic [2:0] {
        SX_RED     = 3'd0,
        SX_YELLOW  = 3'd1,
        SX_GREEN   = 3'd2,
        SX_CYAN    = 3'd3,
        SX_BLUE    = 3'd4,
        SX_MAGENTA = 3'd5
    } sextant_t;

    // Word carried down the pipeline
    typedef struct packed {
        logic [PIX_W-1:0]   pix;
        logic               gray;
        logic [CHAN_W-1:0]  lo;
        logic [CHAN_W-1:0]  hi;
        logic [CHAN_W-1:0]  rng;
        sextant_t           sext;
        logic [PROD_W-1:0]  hrem;
        logic [HUE_Q_W-1:0] hq;
        logic [SHIFT_W-1:0] sm;
        logic [HUE_W-1:0]   h2;
        sextant_t           s;
        logic [J_W-1:0]     j;
        logic [PROD_W-1:0]  prem;
        logic [CHAN_W-1:0]  pq;
    } rhr_item_t;

    // Start hue of a sextant
    function automatic logic [HUE_W-1:0] sx_base(input sextant_t sx);
        logic [HUE_W-1:0] b;
        unique case (sx)
            SX_RED:     b = HUE_W'(0);
            SX_YELLOW:  b = HUE_W'(DEG_SEXT);
            SX_GREEN:   b = HUE_W'(2 * DEG_SEXT);
            SX_CYAN:    b = HUE_W'(3 * DEG_SEXT);
            SX_BLUE:    b = HUE_W'(4 * DEG_SEXT);
            SX_MAGENTA: b = HUE_W'(5 * DEG_SEXT);
            default:    b = HUE_W'(0);
        endcase
        return b;
    endfunction

endpackage

// ===== hw/rtl/rgb_hue_rotate.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_hue_rotate: streaming RGB hue rotator
// Finds min, max and hue of each pixel, adds the configured shift modulo 360
// and rebuilds the pixel from min, max and the new hue. Gray pixels pass.
// ----------------------------------------------------------------------------
// Takes one pixel per clock while the output side does not stall. The nine
// register stages are: channel sort, two stages of the hue divide (three
// quotient bits each, with shift-modulo-360 steps here and in the sort), hue add
// and wrap, sextant split, the difference times offset multiply, two stages
// of the divide by 60, and the rebuild into the output register. The whole
// pipeline advances together; s_tready falls only while the output word is
// held by m_tready low. shift_degrees is taken from cfg_wr_data when
// cfg_wr_en is high and is reduced modulo 360 inside.
module rgb_hue_rotate
    import rhr_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    // Configuration
    input  logic                cfg_wr_en,
    input  logic [SHIFT_W-1:0]  cfg_wr_data,   // shift_degrees
    // Input pixel stream
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [PIX_W-1:0]    s_tdata,       // red_in, green_in, blue_in
    // Output pixel stream
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [PIX_W-1:0]    m_tdata        // red_out, green_out, blue_out
);

    logic [SHIFT_W-1:0] shift_reg;
    logic               adv;
    logic [NSTG:1]      vld_reg;
    rhr_item_t          st_reg  [1:NSTG];
    rhr_item_t          st_next [1:NSTG];
    logic               out_vld_reg;
    logic [PIX_W-1:0]   out_reg;
    logic [PIX_W-1:0]   out_next;

    // Hold the shift register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shift_reg <= '0;
        end else if (cfg_wr_en) begin
            shift_reg <= cfg_wr_data;
        end
    end

    // Advance the whole pipeline unless the output word is held
    assign adv      = !out_vld_reg || m_tready;
    assign s_tready = adv;
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_reg;

    // Stage 1: sort channels, form dividend, first shift modulo steps
    always_comb begin
        logic [CHAN_W-1:0]  r, g, b, num;
        rhr_item_t          it;
        it   = '0;
        r    = s_tdata[0*CHAN_W +: CHAN_W];
        g    = s_tdata[1*CHAN_W +: CHAN_W];
        b    = s_tdata[2*CHAN_W +: CHAN_W];
        it.pix = s_tdata;
        if (r <= g) begin
            if (r <= b) begin
                if (g <= b) begin
                    it.lo = r; it.hi = b; it.sext = SX_CYAN;  num = b - g; it.rng = b - r;
                end else begin
                    it.lo = r; it.hi = g; it.sext = SX_GREEN; num = b - r; it.rng = g - r;
                end
            end else begin
                it.lo = b; it.hi = g; it.sext = SX_YELLOW; num = g - r; it.rng = g - b;
            end
        end else begin
            if (r <= b) begin
                it.lo = g; it.hi = b; it.sext = SX_BLUE;    num = r - g; it.rng = b - g;
            end else if (g <= b) begin
                it.lo = g; it.hi = r; it.sext = SX_MAGENTA; num = r - b; it.rng = r - g;
            end else begin
                it.lo = b; it.hi = r; it.sext = SX_RED;     num = g - b; it.rng = r - b;
            end
        end
        it.gray = (it.rng == '0);
        it.hrem = PROD_W'(num) * PROD_W'(DEG_SEXT);
        it.sm   = shift_reg;
        for (int k = MOD_Q_W - 1; k >= MOD_S1_LO; k--) begin
            if (it.sm >= SHIFT_W'(DEG_FULL << k)) begin
                it.sm = it.sm - SHIFT_W'(DEG_FULL << k);
            end
        end
        st_next[1] = it;
    end

    // Stage 2: upper hue quotient bits, middle shift modulo steps
    always_comb begin
        rhr_item_t it;
        it = st_reg[1];
        for (int k = HUE_Q_W - 1; k >= HUE_S2_LO; k--) begin
            if (it.hrem >= (PROD_W'(it.rng) << k)) begin
                it.hrem  = it.hrem - (PROD_W'(it.rng) << k);
                it.hq[k] = 1'b1;
            end
        end
        for (int k = MOD_S1_LO - 1; k >= MOD_S2_LO; k--) begin
            if (it.sm >= SHIFT_W'(DEG_FULL << k)) begin
                it.sm = it.sm - SHIFT_W'(DEG_FULL << k);
            end
        end
        st_next[2] = it;
    end

    // Stage 3: lower hue quotient bits, last shift modulo steps
    always_comb begin
        rhr_item_t it;
        it = st_reg[2];
        for (int k = HUE_S2_LO - 1; k >= 0; k--) begin
            if (it.hrem >= (PROD_W'(it.rng) << k)) begin
                it.hrem  = it.hrem - (PROD_W'(it.rng) << k);
                it.hq[k] = 1'b1;
            end
        end
        for (int k = MOD_S2_LO - 1; k >= 0; k--) begin
            if (it.sm >= SHIFT_W'(DEG_FULL << k)) begin
                it.sm = it.sm - SHIFT_W'(DEG_FULL << k);
            end
        end
        st_next[3] = it;
    end

    // Stage 4: hue plus shift, wrapped into 0..359
    always_comb begin
        rhr_item_t        it;
        logic [HSUM_W-1:0] hsum;
        it   = st_reg[3];
        hsum = HSUM_W'(sx_base(it.sext)) + HSUM_W'(it.hq) + HSUM_W'(it.sm[HUE_W-1:0]);
        if (hsum >= HSUM_W'(DEG_FULL)) begin
            hsum = hsum - HSUM_W'(DEG_FULL);
        end
        it.h2 = hsum[HUE_W-1:0];
        st_next[4] = it;
    end

    // Stage 5: split new hue into sextant and offset
    always_comb begin
        rhr_item_t        it;
        logic [HUE_W-1:0] joff;
        it = st_reg[4];
        priority if (it.h2 < HUE_W'(DEG_SEXT)) begin
            it.s = SX_RED;
        end else if (it.h2 < HUE_W'(2 * DEG_SEXT)) begin
            it.s = SX_YELLOW;
        end else if (it.h2 < HUE_W'(3 * DEG_SEXT)) begin
            it.s = SX_GREEN;
        end else if (it.h2 < HUE_W'(4 * DEG_SEXT)) begin
            it.s = SX_CYAN;
        end else if (it.h2 < HUE_W'(5 * DEG_SEXT)) begin
            it.s = SX_BLUE;
        end else begin
            it.s = SX_MAGENTA;
        end
        joff = it.h2 - sx_base(it.s);
        it.j = joff[J_W-1:0];
        st_next[5] = it;
    end

    // Stage 6: difference times offset
    always_comb begin
        rhr_item_t it;
        it      = st_reg[5];
        it.prem = PROD_W'(it.rng) * PROD_W'(it.j);
        it.pq   = '0;
        st_next[6] = it;
    end

    // Stage 7: upper bits of product / 60
    always_comb begin
        rhr_item_t it;
        it = st_reg[6];
        for (int k = CHAN_W - 1; k >= PQ_S7_LO; k--) begin
            if (it.prem >= PROD_W'(DEG_SEXT << k)) begin
                it.prem  = it.prem - PROD_W'(DEG_SEXT << k);
                it.pq[k] = 1'b1;
            end
        end
        st_next[7] = it;
    end

    // Stage 8: lower bits of product / 60; remainder left in prem
    always_comb begin
        rhr_item_t it;
        it = st_reg[7];
        for (int k = PQ_S7_LO - 1; k >= 0; k--) begin
            if (it.prem >= PROD_W'(DEG_SEXT << k)) begin
                it.prem  = it.prem - PROD_W'(DEG_SEXT << k);
                it.pq[k] = 1'b1;
            end
        end
        st_next[8] = it;
    end

    // Stage 9: rising and falling channels, sextant select, gray bypass
    always_comb begin
        rhr_item_t         it;
        logic [CHAN_W-1:0] up, dn, ro, go, bo;
        it = st_reg[8];
        up = it.lo + it.pq;
        dn = it.hi - (it.pq + CHAN_W'(it.prem != '0));
        unique case (it.s)
            SX_RED:     begin ro = it.hi; go = up;    bo = it.lo; end
            SX_YELLOW:  begin ro = dn;    go = it.hi; bo = it.lo; end
            SX_GREEN:   begin ro = it.lo; go = it.hi; bo = up;    end
            SX_CYAN:    begin ro = it.lo; go = dn;    bo = it.hi; end
            SX_BLUE:    begin ro = up;    go = it.lo; bo = it.hi; end
            SX_MAGENTA: begin ro = it.hi; go = it.lo; bo = dn;    end
            default:    begin ro = it.hi; go = it.lo; bo = dn;    end
        endcase
        if (it.gray) begin
            out_next = it.pix;
        end else begin
            out_next = {bo, go, ro};
        end
    end

    // Advance valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end else if (adv) begin
            vld_reg     <= {vld_reg[NSTG-1:1], s_tvalid};
            out_vld_reg <= vld_reg[NSTG];
        end
    end

    // Advance payload words
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 1; i <= NSTG; i++) begin
                st_reg[i] <= st_next[i];
            end
            out_reg <= out_next;
        end
    end

endmodule

// ===== hw/rtl/rhr_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhr_checker: port-level checks for the RGB hue rotator
// Watches reset, stall and backpressure behavior on the stream ports.
// ----------------------------------------------------------------------------
module rhr_checker
    import rhr_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tready,
    input  logic               m_tvalid,
    input  logic               m_tready,
    input  logic [PIX_W-1:0]   m_tdata
);

    // Drop output word after reset
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output word valid right after reset");

    // Hold a stalled output word
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled output word changed or vanished");

    // Block new words while the output word is held
    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input accepted while output word held");

    // Take words whenever the output side is free
    a_ready_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid || m_tready |-> s_tready)
        else $error("input stalled with a free output side");

endmodule

bind rgb_hue_rotate rhr_checker u_rhr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for the streaming RGB hue rotator
// Sends a directed set of pixels and then 1280 random pixels under several
// hue shifts. A behavioral predictor computes each expected pixel that the
// directed table does not list. The random idling on both sides, one long
// output stall and a stretch with no idling exercise the handshake.
// ----------------------------------------------------------------------------
module tb_top;
    import rhr_pkg::*;

    localparam int CHAN_MAX      = (1 << CHAN_W) - 1;
    localparam int IDLE_PCT      = 34;
    localparam int PHASES        = 8;
    localparam int PHASE_PIXELS  = 160;
    localparam int CALM_PHASE    = 4;
    localparam int HOLD_AT       = 580;
    localparam int HOLD_CYCLES   = 150;
    localparam int DRAIN_CYCLES  = 20;
    localparam int PRINT_LIMIT   = 30;

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               cfg_wr_en;
    logic [SHIFT_W-1:0] cfg_wr_data;
    logic               s_tvalid;
    logic               s_tready;
    logic [PIX_W-1:0]   s_tdata;     // red_in, green_in, blue_in
    logic               m_tvalid;
    logic               m_tready;
    logic [PIX_W-1:0]   m_tdata;     // red_out, green_out, blue_out

    // One row of the directed pixel table
    typedef struct {
        logic [SHIFT_W-1:0] shift;
        logic [PIX_W-1:0]   pix;
        bit                 known;
        logic [PIX_W-1:0]   want;
    } probe_t;

    probe_t             probe_table[$];
    logic [PIX_W-1:0]   expected_pixels[$];
    logic [SHIFT_W-1:0] shift_now = '0;
    bit                 calm = 1'b0;
    int                 mismatch_count = 0;
    int                 pixels_sent = 0;
    int                 pixels_checked = 0;
    int                 shifts_written = 0;

    rgb_hue_rotate dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always #5 aclk = ~aclk;

    // Predict the rotated pixel from min, max and the shifted hue
    function automatic logic [PIX_W-1:0] rotate_hue(input logic [PIX_W-1:0] pix,
                                                    input logic [SHIFT_W-1:0] shift);
        logic [CHAN_W-1:0] r, g, b, lo, hi, up, dn;
        int unsigned       num, hue, h2, span, dj;
        sextant_t          base_sx, sx;
        r = pix[CHAN_W-1:0];
        g = pix[2*CHAN_W-1:CHAN_W];
        b = pix[PIX_W-1:2*CHAN_W];
        // order the channels and pick the sextant the hue starts from
        if (r <= g) begin
            if (r <= b) begin
                if (g <= b) begin
                    lo = r; hi = b; base_sx = SX_CYAN;   num = 32'(b - g);
                end else begin
                    lo = r; hi = g; base_sx = SX_GREEN;  num = 32'(b - r);
                end
            end else begin
                lo = b; hi = g; base_sx = SX_YELLOW; num = 32'(g - r);
            end
        end else if (r <= b) begin
            lo = g; hi = b; base_sx = SX_BLUE;    num = 32'(r - g);
        end else if (g <= b) begin
            lo = g; hi = r; base_sx = SX_MAGENTA; num = 32'(r - b);
        end else begin
            lo = b; hi = r; base_sx = SX_RED;     num = 32'(g - b);
        end
        // gray passes unchanged
        if (lo == hi)
            return pix;
        span = 32'(hi - lo);
        hue  = int'(base_sx) * DEG_SEXT + (DEG_SEXT * num) / span;
        h2   = (hue + shift % DEG_FULL) % DEG_FULL;
        sx   = sextant_t'(h2 / DEG_SEXT);
        dj   = span * (h2 % DEG_SEXT);
        up   = CHAN_W'(lo + dj / DEG_SEXT);
        dn   = CHAN_W'(hi - (dj + DEG_SEXT - 1) / DEG_SEXT);
        case (sx)
            SX_RED:     begin r = hi; g = up; b = lo; end
            SX_YELLOW:  begin r = dn; g = hi; b = lo; end
            SX_GREEN:   begin r = lo; g = hi; b = up; end
            SX_CYAN:    begin r = lo; g = dn; b = hi; end
            SX_BLUE:    begin r = up; g = lo; b = hi; end
            default:    begin r = hi; g = lo; b = dn; end
        endcase
        return {b, g, r};
    endfunction

    // Random pixel, biased toward gray, tied and saturated colors
    function automatic logic [PIX_W-1:0] random_pixel();
        logic [CHAN_W-1:0] c[3];
        int unsigned       pick, a, k;
        pick = $urandom_range(99);
        for (k = 0; k < 3; k++)
            c[k] = CHAN_W'($urandom_range(CHAN_MAX));
        a = $urandom_range(2);
        if (pick < 15) begin
            c[1] = c[0];
            c[2] = c[0];
        end else if (pick < 35) begin
            c[(a + 1 + $urandom_range(1)) % 3] = c[a];
        end else if (pick < 50) begin
            c[a] = '0;
            c[(a + 1 + $urandom_range(1)) % 3] = '1;
        end else if (pick < 60) begin
            for (k = 0; k < 3; k++)
                if ($urandom_range(2) != 0)
                    c[k] = $urandom_range(1) ? '1 : '0;
        end
        return {c[2], c[1], c[0]};
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("%0t mismatch on word %0d: %s got %0d expected %0d",
                     $time, pixels_checked, what, got, want);
    endtask

    task automatic add_probe(input logic [SHIFT_W-1:0] shift,
                             input int r, input int g, input int b,
                             input bit known, input int er, input int eg, input int eb);
        probe_t row;
        row.shift = shift;
        row.pix   = {CHAN_W'(b), CHAN_W'(g), CHAN_W'(r)};
        row.known = known;
        row.want  = {CHAN_W'(eb), CHAN_W'(eg), CHAN_W'(er)};
        probe_table.push_back(row);
    endtask

    // Offer one pixel after a random gap; record its expectation on acceptance
    task automatic send_pixel(input logic [PIX_W-1:0] pix, input bit known,
                              input logic [PIX_W-1:0] want);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        do @(posedge aclk); while (!s_tready);
        expected_pixels.push_back(known ? want : rotate_hue(pix, shift_now));
        pixels_sent++;
        @(negedge aclk);
    endtask

    // Write the shift once the pipeline has drained
    task automatic set_shift(input logic [SHIFT_W-1:0] value);
        s_tvalid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        shift_now = value;
        shifts_written++;
    endtask

    // Check each output word against the oldest expectation
    always @(posedge aclk) begin : check_words
        logic [PIX_W-1:0] want;
        string            names[3];
        int               k;
        names = '{"red", "green", "blue"};
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_pixels.size() == 0) begin
                report_mismatch("unexpected word, pixel", int'(m_tdata), 0);
            end else begin
                want = expected_pixels.pop_front();
                for (k = 0; k < 3; k++)
                    if (m_tdata[k*CHAN_W +: CHAN_W] !== want[k*CHAN_W +: CHAN_W])
                        report_mismatch(names[k], int'(m_tdata[k*CHAN_W +: CHAN_W]),
                                        int'(want[k*CHAN_W +: CHAN_W]));
            end
            pixels_checked++;
        end
    end

    // Output side: random idling, plus one long hold-off to back up the pipeline
    initial begin : receiver
        int hold_left;
        bit hold_done;
        bit ready;
        hold_left = 0;
        hold_done = 1'b0;
        m_tready  = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                hold_left--;
                ready = 1'b0;
            end else if (!hold_done && pixels_checked >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                ready     = 1'b0;
            end else begin
                ready = calm || ($urandom_range(99) >= IDLE_PCT);
            end
            m_tready <= ready;
        end
    end

    // Stimulus
    initial begin : stimulus
        logic [SHIFT_W-1:0] phase_shift[PHASES];
        int                 p, n;
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;

        // gray, primaries, secondaries and the hue that wraps from 360 to 0
        add_probe(0, 0, 0, 0, 1, 0, 0, 0);
        add_probe(0, 255, 255, 255, 1, 255, 255, 255);
        add_probe(0, 128, 128, 128, 1, 128, 128, 128);
        add_probe(0, 255, 0, 0, 1, 255, 0, 0);
        add_probe(0, 0, 255, 0, 1, 0, 255, 0);
        add_probe(0, 0, 0, 255, 1, 0, 0, 255);
        add_probe(0, 255, 255, 0, 1, 255, 255, 0);
        add_probe(0, 0, 255, 255, 1, 0, 255, 255);
        add_probe(0, 255, 0, 255, 1, 255, 0, 255);
        add_probe(0, 200, 10, 10, 1, 200, 10, 10);
        add_probe(0, 1, 0, 0, 0, 0, 0, 0);
        add_probe(0, 12, 200, 99, 0, 0, 0, 0);
        add_probe(0, 128, 127, 129, 0, 0, 0, 0);
        // a third of a turn moves red to green
        add_probe(120, 255, 0, 0, 1, 0, 255, 0);
        add_probe(120, 64, 64, 64, 1, 64, 64, 64);
        add_probe(120, 10, 200, 30, 0, 0, 0, 0);
        // largest shift, reduced modulo 360, then a shift of 359
        add_probe(16'hFFFF, 7, 7, 7, 1, 7, 7, 7);
        add_probe(16'hFFFF, 255, 0, 0, 0, 0, 0, 0);
        add_probe(16'hFFFF, 1, 2, 3, 0, 0, 0, 0);
        add_probe(16'hFFFF, 255, 254, 0, 0, 0, 0, 0);
        add_probe(359, 0, 0, 1, 0, 0, 0, 0);
        add_probe(359, 255, 128, 0, 0, 0, 0, 0);
        // a full turn is no rotation
        add_probe(360, 255, 0, 0, 1, 255, 0, 0);
        add_probe(360, 0, 255, 0, 1, 0, 255, 0);

        phase_shift[0] = 16'hFFFF;
        phase_shift[1] = 359;
        phase_shift[2] = 360;
        phase_shift[3] = 1;
        phase_shift[4] = 180;
        phase_shift[5] = SHIFT_W'($urandom_range(16'hFFFF));
        phase_shift[6] = SHIFT_W'($urandom_range(16'hFFFF));
        phase_shift[7] = 0;

        // hold reset, then release it
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed table
        foreach (probe_table[n]) begin
            if (probe_table[n].shift != shift_now)
                set_shift(probe_table[n].shift);
            send_pixel(probe_table[n].pix, probe_table[n].known, probe_table[n].want);
        end

        // random phases, one of them without any idling
        for (p = 0; p < PHASES; p++) begin
            set_shift(phase_shift[p]);
            calm = (p == CALM_PHASE);
            for (n = 0; n < PHASE_PIXELS; n++)
                send_pixel(random_pixel(), 1'b0, '0);
        end
        calm = 1'b0;

        // drain, then allow stray words a chance to show
        s_tvalid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        $display("Sent %0d pixels (%0d directed) under %0d shift settings;",
                 pixels_sent, probe_table.size(), shifts_written + 1);
        $display("checked %0d output words, %0d mismatches.", pixels_checked, mismatch_count);
        if (mismatch_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

    // Watchdog
    initial begin : watchdog
        #1_000_000;
        $display("tb_top failed");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/rhr_pkg.sv
hw/rtl/rgb_hue_rotate.sv
hw/rtl/rhr_checker.sv
tb/tb_top.sv
